// File: src/assert_macros.svh
// Assertion macros shared by the predictor modules.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define MLP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition in one cycle that implies a condition in the next cycle.
`define MLP_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

// File: src/mlp_pkg.sv
// Shared types and fixed field widths for the Markov layer predictor.
// Used by mlp_argmax and markov_layer_predictor_core; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package mlp_pkg;

  // Fixed widths of the word fields and of one transition count.
  localparam int unsigned EnterW = 5;
  localparam int unsigned PredW  = 6;
  localparam int unsigned SpanW  = 2;
  localparam int unsigned CountW = 32;

  // Sequencer states, one-hot.
  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_CLEAR  = 7'b0000010,
    ST_INC_RD = 7'b0000100,
    ST_INC_WR = 7'b0001000,
    ST_SCAN   = 7'b0010000,
    ST_DRAIN  = 7'b0100000,
    ST_DONE   = 7'b1000000
  } state_e;

  // Control from the sequencer to the row scan unit.
  typedef struct packed {
    logic init;    // load the empty-row default and clear the running maximum
    logic sample;  // a count read from the row is on the data input
  } scan_ctrl_t;

endpackage

`default_nettype wire

// File: src/mlp_count_mem.sv
// Single-port synchronous memory holding the transition counts.
// One access per cycle, read data registered; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

module mlp_count_mem #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10,
  parameter int unsigned DW    = 32
) (
  input  wire logic          clk_i,
  input  wire logic          en_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] addr_i,
  input  wire logic [DW-1:0] wdata_i,
  output logic      [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_q;

  // Write, or read with the read data registered.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: src/mlp_argmax.sv
// Running maximum over the counts of one row, first maximum wins.
// Depends on mlp_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module mlp_argmax #(
  parameter int unsigned CW = 5,
  parameter int unsigned BW = 6
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire mlp_pkg::scan_ctrl_t        ctrl_i,
  input  wire logic [BW-1:0]              init_best_i,
  input  wire logic [CW-1:0]              col_i,
  input  wire logic [mlp_pkg::CountW-1:0] count_i,
  output logic      [BW-1:0]              best_o
);

  logic [mlp_pkg::CountW-1:0] top_q, top_d;
  logic [BW-1:0]              best_q, best_d;
  logic                       take;

  // A strictly larger count takes over, so ties keep the lower column.
  assign take = ctrl_i.sample && !ctrl_i.init && (count_i > top_q);

  always_comb begin
    top_d  = top_q;
    best_d = best_q;
    if (ctrl_i.init) begin
      top_d  = '0;
      best_d = init_best_i;
    end else if (take) begin
      top_d  = count_i;
      best_d = BW'(col_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_q  <= '0;
      best_q <= '0;
    end else begin
      top_q  <= top_d;
      best_q <= best_d;
    end
  end

  assign best_o = best_q;

  `MLP_ASSERT_NEXT(a_new_max_taken, take, best_o == BW'($past(col_i)), "new maximum not taken")

endmodule

`default_nettype wire

// File: src/markov_layer_predictor_core.sv
// Markov next-layer predictor: sequencer, count memory and row scan.
// Depends on mlp_pkg, mlp_count_mem, mlp_argmax and assert_macros.svh.
//
// Use: drive entered_layer_i and raise start while busy is low; the word is
// taken at that edge. If the entered layer is in range and not the present
// one, the block bumps the count for the transition from the present layer
// to the entered one (saturating) and makes the entered layer the present
// one. It then scans the present layer's count row for its largest nonzero
// count. An empty row predicts the next layer in order. The result word
// shows for one cycle on predicted_layer_o and prefetch_span_o with valid_o
// high; the receiver cannot stall it. From accept the sequencer passes
// through ST_INC_RD and ST_INC_WR when a count is bumped, then ST_SCAN over
// the row, ST_DRAIN and ST_DONE; valid_o is registered from ST_DONE. The scan
// reads one count per cycle through the single memory port. busy is low again
// in the cycle valid_o is high, so the next word may start there. Reset: after
// rst_ni goes high, a clearing pass writes zero to every count, with busy
// high. The present layer resets to zero.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module markov_layer_predictor_core #(
  parameter int unsigned NUM_LAYERS = 32,
  parameter int unsigned LOOKAHEAD  = 2
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start,
  input  wire logic [mlp_pkg::EnterW-1:0]  entered_layer_i,
  output logic                             busy,
  output logic                             valid_o,
  output logic      [mlp_pkg::PredW-1:0]   predicted_layer_o,
  output logic      [mlp_pkg::SpanW-1:0]   prefetch_span_o
);

  localparam int unsigned DEPTH = NUM_LAYERS * NUM_LAYERS;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned CW    = $clog2(NUM_LAYERS);
  localparam int unsigned BW    = $clog2(NUM_LAYERS + 1);
  localparam int unsigned SW    = (BW > 5) ? BW : 5;

  mlp_pkg::state_e state_q, state_d;

  logic [mlp_pkg::EnterW-1:0] present_q, present_d;
  logic [mlp_pkg::EnterW-1:0] entered_q, entered_d;
  logic [AW-1:0]              clr_q, clr_d;
  logic [CW-1:0]              col_q, col_d;
  logic                       smp_vld_q, smp_vld_d;
  logic [CW-1:0]              smp_col_q, smp_col_d;
  logic                       valid_q, valid_d;
  logic [mlp_pkg::PredW-1:0]  pred_q, pred_d;
  logic [mlp_pkg::SpanW-1:0]  span_q, span_d;

  logic                       mem_en, mem_we;
  logic [AW-1:0]              mem_addr;
  logic [mlp_pkg::CountW-1:0] mem_wdata, mem_rdata, count_inc;
  logic [AW-1:0]              row_base, inc_addr;
  logic                       in_range;
  logic [BW-1:0]              best, init_best;
  logic [SW-1:0]              rem, span_full;
  mlp_pkg::scan_ctrl_t        scan_ctrl;

  // Address arithmetic for the present row.
  assign row_base  = AW'(present_q) * AW'(NUM_LAYERS);
  assign inc_addr  = row_base + AW'(entered_q);
  assign in_range  = (32'(entered_layer_i) < NUM_LAYERS);
  assign count_inc = (mem_rdata == '1) ? mem_rdata : mem_rdata + mlp_pkg::CountW'(1);
  assign init_best = BW'(present_q) + BW'(1);

  // Span: layers from the prediction that stay below the layer count.
  always_comb begin
    rem = '0;
    if (32'(best) < NUM_LAYERS) begin
      rem = SW'(NUM_LAYERS) - SW'(best);
    end
    span_full = (32'(rem) < LOOKAHEAD) ? rem : SW'(LOOKAHEAD);
  end

  // Sequencer: clear, bump the transition count, scan the row, report.
  always_comb begin
    state_d   = state_q;
    present_d = present_q;
    entered_d = entered_q;
    clr_d     = clr_q;
    col_d     = col_q;
    smp_vld_d = 1'b0;
    smp_col_d = smp_col_q;
    valid_d   = 1'b0;
    pred_d    = pred_q;
    span_d    = span_q;
    mem_en    = 1'b0;
    mem_we    = 1'b0;
    mem_addr  = inc_addr;
    mem_wdata = count_inc;
    case (state_q)
      mlp_pkg::ST_CLEAR: begin
        mem_en    = 1'b1;
        mem_we    = 1'b1;
        mem_addr  = clr_q;
        mem_wdata = '0;
        clr_d     = clr_q + AW'(1);
        if (clr_q == AW'(DEPTH - 1)) begin
          clr_d   = '0;
          state_d = mlp_pkg::ST_IDLE;
        end
      end
      mlp_pkg::ST_IDLE: begin
        if (start) begin
          entered_d = entered_layer_i;
          if (in_range && (entered_layer_i != present_q)) begin
            state_d = mlp_pkg::ST_INC_RD;
          end else begin
            state_d = mlp_pkg::ST_SCAN;
          end
        end
      end
      mlp_pkg::ST_INC_RD: begin
        mem_en  = 1'b1;
        state_d = mlp_pkg::ST_INC_WR;
      end
      mlp_pkg::ST_INC_WR: begin
        mem_en    = 1'b1;
        mem_we    = 1'b1;
        present_d = entered_q;
        state_d   = mlp_pkg::ST_SCAN;
      end
      mlp_pkg::ST_SCAN: begin
        mem_en    = 1'b1;
        mem_addr  = row_base + AW'(col_q);
        smp_vld_d = 1'b1;
        smp_col_d = col_q;
        col_d     = col_q + CW'(1);
        if (col_q == CW'(NUM_LAYERS - 1)) begin
          col_d   = '0;
          state_d = mlp_pkg::ST_DRAIN;
        end
      end
      mlp_pkg::ST_DRAIN: begin
        state_d = mlp_pkg::ST_DONE;
      end
      mlp_pkg::ST_DONE: begin
        valid_d = 1'b1;
        pred_d  = mlp_pkg::PredW'(best);
        span_d  = span_full[mlp_pkg::SpanW-1:0];
        state_d = mlp_pkg::ST_IDLE;
      end
      default: begin
        state_d = mlp_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= mlp_pkg::ST_CLEAR;
      present_q <= '0;
      clr_q     <= '0;
      col_q     <= '0;
      smp_vld_q <= 1'b0;
      valid_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      present_q <= present_d;
      clr_q     <= clr_d;
      col_q     <= col_d;
      smp_vld_q <= smp_vld_d;
      valid_q   <= valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    entered_q <= entered_d;
    smp_col_q <= smp_col_d;
    pred_q    <= pred_d;
    span_q    <= span_d;
  end

  // Transition count storage.
  mlp_count_mem #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .DW    (mlp_pkg::CountW)
  ) u_mem (
    .clk_i   (clk_i),
    .en_i    (mem_en),
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  // Row scan unit.
  assign scan_ctrl.init   = (state_q == mlp_pkg::ST_SCAN) && (col_q == '0);
  assign scan_ctrl.sample = smp_vld_q;

  mlp_argmax #(
    .CW (CW),
    .BW (BW)
  ) u_argmax (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (scan_ctrl),
    .init_best_i (init_best),
    .col_i       (smp_col_q),
    .count_i     (mem_rdata),
    .best_o      (best)
  );

  assign busy              = (state_q != mlp_pkg::ST_IDLE);
  assign valid_o           = valid_q;
  assign predicted_layer_o = pred_q;
  assign prefetch_span_o   = span_q;

  `MLP_ASSERT_NEXT(a_strobe_single, valid_o, !valid_o, "result strobe lasted more than one cycle")
  `MLP_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted word did not raise busy")
  `MLP_ASSERT(a_strobe_idle, !valid_o || !busy, "result strobe while busy")
  `MLP_ASSERT(a_present_range, 32'(present_q) < NUM_LAYERS, "present layer out of range")

endmodule

`default_nettype wire
